@@ src/looping_linear_interp_resampler_unit_assert.svh @@
// Assertion macros for the looping resampler.
`ifndef LOOPING_LINEAR_INTERP_RESAMPLER_UNIT_ASSERT_SVH
`define LOOPING_LINEAR_INTERP_RESAMPLER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define LLIR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("resampler check failed");
// Check a property on every rising edge, reset included.
`define LLIR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("resampler check failed");
`else
`define LLIR_ASSERT(lbl, clk, rst, prop)
`define LLIR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ src/llir_pkg.sv @@
// Shared types and constants of the looping resampler.
package llir_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int FRAC_BITS      = 16;
   localparam int ADDR_BITS      = 16;
   localparam int PHASE_INT_BITS = 32;
   localparam int LEN_BITS       = 17;
   localparam int STEP_BITS      = 20;
   localparam int POS_BITS       = 16;
   localparam int CSR_DATA_BITS  = 20;
   localparam int CSR_INDEX_BITS = 2;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [LEN_BITS-1:0]  LEN_RESET    = 17'd0;
   localparam logic [STEP_BITS-1:0] STEP_RESET   = 20'h10000;
   localparam logic                 DIRECT_RESET = 1'b1;
   localparam logic [LEN_BITS-1:0]  BLOCK_RESET  = 17'd1024;
   localparam logic [LEN_BITS-1:0]  BLOCK_MAX    = 17'h10000;
   localparam logic [LEN_BITS-1:0]  BLOCK_MIN    = 17'd1;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_SEEK = 2'd1,
      OP_NEXT = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SOURCE_LENGTH = 2'd0,
      CSR_STEP_RATIO    = 2'd1,
      CSR_DIRECT_MODE   = 2'd2,
      CSR_BLOCK_LENGTH  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [LEN_BITS-1:0]  loop_len;
      logic [STEP_BITS-1:0] step;
      logic                 direct;
      logic [LEN_BITS-1:0]  block_len;
   } cfg_type;

   typedef struct packed {
      op_type                        op;
      logic [LEN_BITS-1:0]           index;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [FRAC_BITS-1:0]          frac;
   } item_type;

endpackage

@@ src/llir_div.sv @@
// Iterative remainder unit, one dividend bit per cycle.
module llir_div #(
   parameter int DW = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DW-1:0]                 dividend,
   input  logic [llir_pkg::LEN_BITS-1:0] divisor,
   output logic                          done,
   output logic [llir_pkg::LEN_BITS-1:0] remainder
);

   localparam int LW    = llir_pkg::LEN_BITS;
   localparam int CNT_W = $clog2(DW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    num_ff, num_in;
   logic [LW-1:0]    rem_ff, rem_in;
   logic [LW-1:0]    den_ff, den_in;
   logic [LW:0]      trial;
   logic             fits;

   assign trial = {rem_ff, num_ff[DW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DW);
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // restoring step: subtract when the partial remainder reaches the divisor
         rem_in = fits ? LW'(trial - {1'b0, den_ff}) : trial[LW-1:0];
         num_in = num_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ src/llir_queue.sv @@
// Short word queue between the front and back sections.
module llir_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  llir_pkg::item_type   item_in,
   output logic                 full,
   input  logic                 pop,
   output llir_pkg::item_type   item_out,
   output logic                 empty
);

   localparam int PW = llir_pkg::QUEUE_PTR_BITS;

   llir_pkg::item_type slot_ff [llir_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = count_ff == (PW + 1)'(llir_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign item_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

@@ src/llir_front.sv @@
// Front section: accepts words, reduces seek phases and load addresses.
module llir_front #(
   parameter int SAMPLE_DEPTH = 65536
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  llir_pkg::cfg_type                          cfg,
   input  logic                                       push,
   output logic                                       full,
   input  logic [1:0]                                 req_opcode,
   input  logic [llir_pkg::ADDR_BITS-1:0]             req_address,
   input  logic signed [llir_pkg::SAMPLE_BITS-1:0]    req_sample_value,
   input  logic [llir_pkg::PHASE_INT_BITS-1:0]        req_start_phase_int,
   input  logic [llir_pkg::FRAC_BITS-1:0]             req_start_phase_frac,
   output logic                                       q_push,
   output llir_pkg::item_type                         q_item,
   input  logic                                       q_full
);

   localparam int LW = llir_pkg::LEN_BITS;
   localparam int PB = llir_pkg::PHASE_INT_BITS;
   localparam logic [24:0] DEPTH_C = 25'(SAMPLE_DEPTH);

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_DIV  = 2'b10
   } fstate_type;

   fstate_type         state_ff, state_in;
   llir_pkg::item_type item_ff, item_in;
   llir_pkg::item_type new_item;
   logic               accept, need_div, keep;
   logic               div_start, div_done;
   logic [PB-1:0]      div_dividend;
   logic [LW-1:0]      div_divisor, div_rem;

   assign full   = (state_ff != F_IDLE) || q_full;
   assign accept = push && !full;

   always_comb begin
      new_item        = '0;
      new_item.sample = req_sample_value;
      new_item.frac   = cfg.direct ? '0 : req_start_phase_frac;
      need_div        = 1'b0;
      keep            = 1'b1;
      div_dividend    = req_start_phase_int;
      div_divisor     = cfg.loop_len;
      case (llir_pkg::op_type'(req_opcode))
         llir_pkg::OP_LOAD: begin
            new_item.op    = llir_pkg::OP_LOAD;
            new_item.index = LW'(req_address);
            div_dividend   = PB'(req_address);
            div_divisor    = LW'(SAMPLE_DEPTH);
            need_div       = 25'(req_address) >= DEPTH_C;
         end
         llir_pkg::OP_SEEK: begin
            new_item.op = llir_pkg::OP_SEEK;
            if (cfg.loop_len == '0) begin
               new_item.index = '0;
            end else if (req_start_phase_int < PB'(cfg.loop_len)) begin
               new_item.index = LW'(req_start_phase_int);
            end else begin
               need_div = 1'b1;
            end
         end
         llir_pkg::OP_NEXT: begin
            new_item.op = llir_pkg::OP_NEXT;
         end
         default: begin
            // unused opcode: drop the word
            keep = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      div_start = 1'b0;
      q_push    = 1'b0;
      q_item    = new_item;
      case (state_ff)
         F_IDLE: begin
            if (accept && keep) begin
               if (need_div) begin
                  item_in   = new_item;
                  div_start = 1'b1;
                  state_in  = F_DIV;
               end else begin
                  q_push = 1'b1;
               end
            end
         end
         F_DIV: begin
            // queue only drains meanwhile, so the slot reserved at accept stays free
            q_item       = item_ff;
            q_item.index = div_rem;
            if (div_done) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   llir_div #(
      .DW(PB)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

endmodule

@@ src/llir_back.sv @@
// Back section: sample store, phase state, interpolation and result register.
module llir_back #(
   parameter int SAMPLE_DEPTH = 65536
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  llir_pkg::cfg_type                       cfg,
   input  logic                                    q_empty,
   input  llir_pkg::item_type                      q_item,
   output logic                                    q_pop,
   output logic                                    empty,
   input  logic                                    pop,
   output logic signed [llir_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                                    rsp_last_in_block
);

   localparam int AW = $clog2(SAMPLE_DEPTH);
   localparam int LW = llir_pkg::LEN_BITS;
   localparam int SB = llir_pkg::SAMPLE_BITS;
   localparam int FB = llir_pkg::FRAC_BITS;
   localparam int PW = llir_pkg::POS_BITS;
   localparam int SW = llir_pkg::STEP_BITS;
   localparam int MW = 2 * (SB + 1);
   localparam int CW = SW + 1 - FB;

   typedef enum logic [6:0] {
      B_IDLE   = 7'b0000001,
      B_REDUCE = 7'b0000010,
      B_READ2  = 7'b0000100,
      B_MULT   = 7'b0001000,
      B_SUM    = 7'b0010000,
      B_ADVMOD = 7'b0100000,
      B_OUT    = 7'b1000000
   } bstate_type;

   logic signed [SB-1:0] sample_mem [SAMPLE_DEPTH];
   logic signed [SB-1:0] rd_data_ff;

   bstate_type           state_ff, state_in;
   logic [LW-1:0]        idx_ff, idx_in;
   logic [FB-1:0]        frac_ff, frac_in;
   logic [PW-1:0]        bpos_ff, bpos_in;
   logic [LW-1:0]        i1_ff, i1_in;
   logic [LW-1:0]        i2_ff, i2_in;
   logic signed [SB-1:0] s1_ff, s1_in;
   logic signed [MW-1:0] prod_ff, prod_in;
   logic signed [SB-1:0] res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0] rsp_sample_ff, rsp_sample_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_addr;
   logic [LW:0]          next1;
   logic [LW-1:0]        i2;
   logic [SW:0]          phase_sum;
   logic [LW:0]          adv;
   logic [LW+1:0]        adv_sub;
   logic signed [SB:0]   diff;
   logic signed [SB:0]   frac_s;
   logic signed [MW-1:0] rounded;
   logic                 last, slot_free;
   logic                 div_start, div_done;
   logic [LW:0]          div_dividend;
   logic [LW-1:0]        div_rem;

   assign next1     = {1'b0, i1_ff} + (LW + 1)'(1);
   assign i2        = (next1 >= {1'b0, cfg.loop_len}) ? '0 : next1[LW-1:0];
   assign phase_sum = (SW + 1)'(frac_ff) + (SW + 1)'(cfg.step);
   assign adv       = {1'b0, i1_ff} + (LW + 1)'(phase_sum[SW:FB]);
   assign adv_sub   = (LW + 2)'(adv) - (LW + 2)'(cfg.loop_len);
   assign diff      = {rd_data_ff[SB-1], rd_data_ff} - {s1_ff[SB-1], s1_ff};
   assign frac_s    = {1'b0, frac_ff};
   assign rounded   = prod_ff + (MW'(1) <<< (FB - 1));
   assign last      = (LW'(bpos_ff) + LW'(1)) >= cfg.block_len;
   assign slot_free = !rsp_valid_ff || pop;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      frac_in       = frac_ff;
      bpos_in       = bpos_ff;
      i1_in         = i1_ff;
      i2_in         = i2_ff;
      s1_in         = s1_ff;
      prod_in       = prod_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !pop;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = AW'(idx_ff);
      div_start     = 1'b0;
      div_dividend  = (LW + 1)'(idx_ff);
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               case (q_item.op)
                  llir_pkg::OP_LOAD: begin
                     mem_we   = 1'b1;
                     mem_addr = AW'(q_item.index);
                  end
                  llir_pkg::OP_SEEK: begin
                     idx_in  = q_item.index;
                     frac_in = q_item.frac;
                     bpos_in = '0;
                  end
                  llir_pkg::OP_NEXT: begin
                     if (cfg.loop_len == '0) begin
                        // silence: hold the phase
                        res_in   = '0;
                        state_in = B_OUT;
                     end else if (idx_ff >= cfg.loop_len) begin
                        // loop shrank since the seek: reduce the index first
                        div_start = 1'b1;
                        state_in  = B_REDUCE;
                     end else begin
                        mem_re   = 1'b1;
                        i1_in    = idx_ff;
                        state_in = B_READ2;
                     end
                  end
                  default: begin
                     state_in = B_IDLE;
                  end
               endcase
            end
         end
         B_REDUCE: begin
            if (div_done) begin
               mem_re   = 1'b1;
               mem_addr = AW'(div_rem);
               i1_in    = div_rem;
               state_in = B_READ2;
            end
         end
         B_READ2: begin
            mem_re   = 1'b1;
            mem_addr = AW'(i2);
            i2_in    = i2;
            s1_in    = rd_data_ff;
            state_in = B_MULT;
         end
         B_MULT: begin
            prod_in  = diff * frac_s;
            state_in = B_SUM;
         end
         B_SUM: begin
            state_in = B_OUT;
            if (cfg.direct) begin
               res_in  = s1_ff;
               frac_in = '0;
               idx_in  = i2_ff;
            end else begin
               res_in  = s1_ff + rounded[FB +: SB];
               frac_in = phase_sum[FB-1:0];
               if (adv < {1'b0, cfg.loop_len}) begin
                  idx_in = adv[LW-1:0];
               end else if (adv_sub < (LW + 2)'(cfg.loop_len)) begin
                  idx_in = adv_sub[LW-1:0];
               end else begin
                  // wrapped more than once: short loop, fall back to the divider
                  div_dividend = adv;
                  div_start    = 1'b1;
                  state_in     = B_ADVMOD;
               end
            end
         end
         B_ADVMOD: begin
            if (div_done) begin
               idx_in   = div_rem;
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_ff;
               rsp_last_in   = last;
               bpos_in       = last ? '0 : bpos_ff + PW'(1);
               state_in      = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         idx_ff       <= '0;
         frac_ff      <= '0;
         bpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         frac_ff      <= frac_in;
         bpos_ff      <= bpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i1_ff         <= i1_in;
      i2_ff         <= i2_in;
      s1_ff         <= s1_in;
      prod_ff       <= prod_in;
      res_ff        <= res_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // single port: a write wins, otherwise a read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[mem_addr] <= q_item.sample;
      end else if (mem_re) begin
         rd_data_ff <= sample_mem[mem_addr];
      end
   end

   llir_div #(
      .DW(LW + 1)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (cfg.loop_len),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign empty             = !rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_last_in_block = rsp_last_ff;

endmodule

@@ src/looping_linear_interp_resampler_unit.sv @@
// Top level of the looping wavetable resampler with linear interpolation.
//
//   port group   direction   handshake            words
//   req_*        in          push / full          load, seek, next
//   rsp_*        out         empty / pop          one per next word
//   csr_*        in          csr_write_enable     four registers, write only
//
// In the back section a next word reads both neighbors through the one read port
// of the sample store, one after the other, then multiplies, sums and outputs.
// A seek whose phase is not below a nonzero loop length passes through the front
// remainder unit; an in-range load or seek does not.
// A next word after the loop shrank, or that wraps past the loop more than once,
// also passes through the back remainder unit.
// Reset is synchronous; the sample store is not cleared. The queue between the
// sections keeps taking words while a result waits to be popped.
`include "looping_linear_interp_resampler_unit_assert.svh"

module looping_linear_interp_resampler_unit #(
   parameter int SAMPLE_DEPTH = 65536
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       push,
   output logic                                       full,
   input  logic [1:0]                                 req_opcode,
   input  logic [llir_pkg::ADDR_BITS-1:0]             req_address,
   input  logic signed [llir_pkg::SAMPLE_BITS-1:0]    req_sample_value,
   input  logic [llir_pkg::PHASE_INT_BITS-1:0]        req_start_phase_int,
   input  logic [llir_pkg::FRAC_BITS-1:0]             req_start_phase_frac,
   output logic                                       empty,
   input  logic                                       pop,
   output logic signed [llir_pkg::SAMPLE_BITS-1:0]    rsp_sample_out,
   output logic                                       rsp_last_in_block,
   input  logic                                       csr_write_enable,
   input  logic [llir_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [llir_pkg::CSR_DATA_BITS-1:0]         csr_write_data
);

   localparam int LW = llir_pkg::LEN_BITS;
   localparam int SW = llir_pkg::STEP_BITS;
   localparam logic [24:0] DEPTH_C = 25'(SAMPLE_DEPTH);

   logic [LW-1:0]      source_length_ff, source_length_in;
   logic [SW-1:0]      step_ratio_ff, step_ratio_in;
   logic               direct_mode_ff, direct_mode_in;
   logic [LW-1:0]      block_length_ff, block_length_in;
   llir_pkg::cfg_type  cfg;
   logic               q_push, q_pop, q_full, q_empty;
   llir_pkg::item_type q_wr_item, q_rd_item;

   always_comb begin
      source_length_in = source_length_ff;
      step_ratio_in    = step_ratio_ff;
      direct_mode_in   = direct_mode_ff;
      block_length_in  = block_length_ff;
      if (csr_write_enable) begin
         case (llir_pkg::csr_index_type'(csr_index))
            llir_pkg::CSR_SOURCE_LENGTH: source_length_in = csr_write_data[LW-1:0];
            llir_pkg::CSR_STEP_RATIO:    step_ratio_in    = csr_write_data[SW-1:0];
            llir_pkg::CSR_DIRECT_MODE:   direct_mode_in   = csr_write_data[0];
            llir_pkg::CSR_BLOCK_LENGTH:  block_length_in  = csr_write_data[LW-1:0];
            default:                     source_length_in = source_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_length_ff <= llir_pkg::LEN_RESET;
         step_ratio_ff    <= llir_pkg::STEP_RESET;
         direct_mode_ff   <= llir_pkg::DIRECT_RESET;
         block_length_ff  <= llir_pkg::BLOCK_RESET;
      end else begin
         source_length_ff <= source_length_in;
         step_ratio_ff    <= step_ratio_in;
         direct_mode_ff   <= direct_mode_in;
         block_length_ff  <= block_length_in;
      end
   end

   // saturate the loop to the store and the block length to its legal range
   always_comb begin
      cfg.loop_len  = (25'(source_length_ff) > DEPTH_C) ? LW'(SAMPLE_DEPTH)
                                                        : source_length_ff;
      cfg.step      = step_ratio_ff;
      cfg.direct    = direct_mode_ff;
      cfg.block_len = block_length_ff;
      if (block_length_ff == '0) begin
         cfg.block_len = llir_pkg::BLOCK_MIN;
      end else if (block_length_ff > llir_pkg::BLOCK_MAX) begin
         cfg.block_len = llir_pkg::BLOCK_MAX;
      end
   end

   llir_front #(
      .SAMPLE_DEPTH(SAMPLE_DEPTH)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .push                 (push),
      .full                 (full),
      .req_opcode           (req_opcode),
      .req_address          (req_address),
      .req_sample_value     (req_sample_value),
      .req_start_phase_int  (req_start_phase_int),
      .req_start_phase_frac (req_start_phase_frac),
      .q_push               (q_push),
      .q_item               (q_wr_item),
      .q_full               (q_full)
   );

   llir_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .item_in  (q_wr_item),
      .full     (q_full),
      .pop      (q_pop),
      .item_out (q_rd_item),
      .empty    (q_empty)
   );

   llir_back #(
      .SAMPLE_DEPTH(SAMPLE_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_empty           (q_empty),
      .q_item            (q_rd_item),
      .q_pop             (q_pop),
      .empty             (empty),
      .pop               (pop),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_last_in_block (rsp_last_in_block)
   );

   `LLIR_ASSERT(a_no_push_when_full, clock, reset, !(q_push && q_full))
   `LLIR_ASSERT(a_no_pop_when_empty, clock, reset, !(q_pop && q_empty))
   `LLIR_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (empty && !full))
   `LLIR_ASSERT(a_loop_fits_store, clock, reset, 25'(cfg.loop_len) <= DEPTH_C)

endmodule

@@ tb/sv/looping_linear_interp_resampler_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench: directed script plus random phases for the looping resampler.
module looping_linear_interp_resampler_unit_tb;
   import llir_pkg::*;

   localparam int SAMPLE_DEPTH  = 65536;
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int RANDOM_WORDS  = 1150;
   localparam int PHASE_WORDS   = 115;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_GAP       = 18;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int MAX_PRINTS    = 100;
   localparam int SCRIPT_ROWS   = 36;

   typedef enum bit {ROW_WORD, ROW_REG} row_kind_e;

   typedef struct packed {
      row_kind_e     kind;
      csr_index_type reg_sel;
      logic [1:0]    op;
      logic [19:0]   arg;
      logic [15:0]   val;
      logic [31:0]   pint;
      logic [15:0]   pfrac;
      bit            typed;
      logic [15:0]   want;
      logic          want_last;
   } script_row_t;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } output_word_t;

   // Rows with typed = 1 carry their own expected word; others use the predictor.
   localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NEXT, 20'h0, 16'h0, 32'h0, 16'h0, 1'b1, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_SEEK, 20'h0, 16'h0, 32'hFFFFFFFF, 16'hFFFF,
        1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NONE, 20'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF,
        1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_LOAD, 20'h0, 16'h7FFF, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_LOAD, 20'h1, 16'h8000, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_LOAD, 20'h2, 16'h0001, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_LOAD, 20'hFFFF, 16'hFFFF, 32'h0, 16'h0,
        1'b0, 16'h0, 1'b0},
      '{ROW_REG, CSR_SOURCE_LENGTH, OP_NONE, 20'h3, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_REG, CSR_DIRECT_MODE, OP_NONE, 20'h0, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_REG, CSR_STEP_RATIO, OP_NONE, 20'h08000, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_REG, CSR_BLOCK_LENGTH, OP_NONE, 20'h2, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_SEEK, 20'h0, 16'h0, 32'hFFFFFFFF, 16'hFFFF,
        1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NEXT, 20'h0, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NEXT, 20'h0, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NEXT, 20'h0, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NEXT, 20'h0, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      // loop length above the store depth saturates
      '{ROW_REG, CSR_SOURCE_LENGTH, OP_NONE, 20'hFFFFF, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_REG, CSR_DIRECT_MODE, OP_NONE, 20'h1, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_SEEK, 20'h0, 16'h0, 32'h0000FFFF, 16'h1234,
        1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NEXT, 20'h0, 16'h0, 32'h0, 16'h0, 1'b1, 16'hFFFF, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NEXT, 20'h0, 16'h0, 32'h0, 16'h0, 1'b1, 16'h7FFF, 1'b1},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_SEEK, 20'h0, 16'h0, 32'hFFFFFFFF, 16'h0,
        1'b0, 16'h0, 1'b0},
      // shrink the loop under the seek index, block length zero
      '{ROW_REG, CSR_SOURCE_LENGTH, OP_NONE, 20'h2, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_REG, CSR_BLOCK_LENGTH, OP_NONE, 20'h0, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NEXT, 20'h0, 16'h0, 32'h0, 16'h0, 1'b1, 16'h8000, 1'b1},
      '{ROW_REG, CSR_DIRECT_MODE, OP_NONE, 20'h0, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_REG, CSR_STEP_RATIO, OP_NONE, 20'hFFFFF, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_SEEK, 20'h0, 16'h0, 32'h0, 16'h8000, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NEXT, 20'h0, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NEXT, 20'h0, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_REG, CSR_STEP_RATIO, OP_NONE, 20'h0, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NEXT, 20'h0, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_REG, CSR_BLOCK_LENGTH, OP_NONE, 20'h1FFFF, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NEXT, 20'h0, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_REG, CSR_SOURCE_LENGTH, OP_NONE, 20'h0, 16'h0, 32'h0, 16'h0, 1'b0, 16'h0, 1'b0},
      '{ROW_WORD, CSR_SOURCE_LENGTH, OP_NEXT, 20'h0, 16'h0, 32'h0, 16'h0, 1'b1, 16'h0, 1'b0}
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          push = 1'b0;
   logic [1:0]                    req_opcode = '0;
   logic [ADDR_BITS-1:0]          req_address = '0;
   logic signed [SAMPLE_BITS-1:0] req_sample_value = '0;
   logic [PHASE_INT_BITS-1:0]     req_start_phase_int = '0;
   logic [FRAC_BITS-1:0]          req_start_phase_frac = '0;
   logic                          pop = 1'b0;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_write_data = '0;
   wire                           full;
   wire                           empty;
   wire signed [SAMPLE_BITS-1:0]  rsp_sample_out;
   wire                           rsp_last_in_block;

   // Predictor state and register copy.
   cfg_type                       regs;
   logic signed [SAMPLE_BITS-1:0] sample_mem [SAMPLE_DEPTH];
   bit                            loaded [SAMPLE_DEPTH];
   int unsigned                   read_pos;
   logic [FRAC_BITS-1:0]          read_frac;
   int unsigned                   block_pos;

   output_word_t pending_outputs [$];
   int           mismatch_count = 0;
   int           words_sent = 0;
   bit           fast_sender = 1'b0;
   bit           fast_sink = 1'b0;
   bit           hold_request = 1'b0;

   looping_linear_interp_resampler_unit #(
      .SAMPLE_DEPTH(SAMPLE_DEPTH)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_opcode           (req_opcode),
      .req_address          (req_address),
      .req_sample_value     (req_sample_value),
      .req_start_phase_int  (req_start_phase_int),
      .req_start_phase_frac (req_start_phase_frac),
      .empty                (empty),
      .pop                  (pop),
      .rsp_sample_out       (rsp_sample_out),
      .rsp_last_in_block    (rsp_last_in_block),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic int unsigned loop_length();
      return (regs.loop_len > SAMPLE_DEPTH) ? SAMPLE_DEPTH : int'(regs.loop_len);
   endfunction

   function automatic int unsigned block_size();
      if (regs.block_len == 0) return 1;
      return (regs.block_len > 65536) ? 65536 : int'(regs.block_len);
   endfunction

   // Apply one word to the predictor; returns 1 when the word yields an output.
   function automatic bit resample_word(input logic [1:0] op, input logic [15:0] addr,
         input logic [15:0] val, input logic [31:0] pint, input logic [15:0] pfrac,
         output output_word_t result);
      int unsigned           len;
      int unsigned           lo;
      int unsigned           hi;
      longint                prod;
      longint unsigned       sum;
      logic signed [15:0]    s1;
      logic signed [15:0]    s2;
      len = loop_length();
      result = '0;
      case (op)
         OP_LOAD: begin
            sample_mem[addr] = val;
            loaded[addr] = 1'b1;
            return 1'b0;
         end
         OP_SEEK: begin
            read_pos = (len != 0) ? pint % len : 0;
            read_frac = regs.direct ? '0 : pfrac;
            block_pos = 0;
            return 1'b0;
         end
         OP_NEXT: ;
         default: return 1'b0;
      endcase
      if (len != 0) begin
         read_pos = read_pos % len;
         lo = read_pos;
         hi = (lo + 1 >= len) ? 0 : lo + 1;
         s1 = sample_mem[lo];
         s2 = sample_mem[hi];
         if (regs.direct) begin
            result.sample = s1;
            read_frac = '0;
            read_pos = hi;
         end else begin
            // round half up: floor of (diff * frac + half) / one
            prod = (longint'(s2) - longint'(s1)) * longint'(read_frac)
                 + (64'sd1 <<< (FRAC_BITS - 1));
            result.sample = 16'(longint'(s1) + (prod >>> FRAC_BITS));
            sum = read_frac + regs.step;
            read_frac = sum[FRAC_BITS-1:0];
            read_pos = (read_pos + 32'(sum >> FRAC_BITS)) % len;
         end
      end
      if (block_pos + 1 >= block_size()) begin
         result.last = 1'b1;
         block_pos = 0;
      end else begin
         result.last = 1'b0;
         block_pos++;
      end
      return 1'b1;
   endfunction

   function automatic logic [15:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_frac();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS) $display("%0t: mismatch: %s", $time, what);
   endtask

   task automatic send_word(input logic [1:0] op, input logic [15:0] addr,
         input logic [15:0] val, input logic [31:0] pint, input logic [15:0] pfrac,
         input bit typed, input output_word_t typed_out);
      int           gap;
      output_word_t predicted;
      gap = $urandom_range(0, MAX_GAP);
      if (fast_sender || $urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_opcode <= op;
      req_address <= addr;
      req_sample_value <= val;
      req_start_phase_int <= pint;
      req_start_phase_frac <= pfrac;
      do @(posedge clock); while (full);
      if (resample_word(op, addr, val, pint, pfrac, predicted))
         pending_outputs.push_back(typed ? typed_out : predicted);
      if (op != OP_NONE) words_sent++;
   endtask

   // Drop push, drain all outputs, then let pending loads and seeks finish.
   task automatic wait_idle();
      push <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type sel, input logic [19:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= sel;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (sel)
         CSR_SOURCE_LENGTH: regs.loop_len = data[LEN_BITS-1:0];
         CSR_STEP_RATIO:    regs.step = data;
         CSR_DIRECT_MODE:   regs.direct = data[0];
         CSR_BLOCK_LENGTH:  regs.block_len = data[LEN_BITS-1:0];
      endcase
   endtask

   // Load both neighbors the next word will read, if they were never written.
   task automatic fill_next_reads();
      int unsigned len;
      int unsigned lo;
      int unsigned hi;
      len = loop_length();
      if (len == 0) return;
      lo = read_pos % len;
      hi = (lo + 1 >= len) ? 0 : lo + 1;
      if (!loaded[lo])
         send_word(OP_LOAD, 16'(lo), random_sample(), $urandom, 16'($urandom), 1'b0, '0);
      if (!loaded[hi])
         send_word(OP_LOAD, 16'(hi), random_sample(), $urandom, 16'($urandom), 1'b0, '0);
   endtask

   task automatic random_word();
      int unsigned len;
      int unsigned pick;
      logic [15:0] addr;
      logic [31:0] pint;
      len = loop_length();
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         fill_next_reads();
         send_word(OP_NEXT, 16'($urandom), 16'($urandom), $urandom, 16'($urandom), 1'b0, '0);
      end else if (pick < 78) begin
         addr = (len != 0 && pick < 72) ? 16'($urandom_range(0, len - 1)) : 16'($urandom);
         send_word(OP_LOAD, addr, random_sample(), $urandom, 16'($urandom), 1'b0, '0);
      end else if (pick < 94) begin
         if (pick < 86 && len != 0) pint = $urandom_range(0, len - 1);
         else if (pick == 93) pint = '1;
         else pint = $urandom;
         send_word(OP_SEEK, 16'($urandom), 16'($urandom), pint, random_frac(), 1'b0, '0);
      end else begin
         send_word(OP_NONE, 16'($urandom), 16'($urandom), $urandom, 16'($urandom), 1'b0, '0);
      end
   endtask

   task automatic configure_phase(input int phase);
      logic [19:0] len;
      logic [19:0] step;
      logic [19:0] blk;
      logic        direct;
      case (phase)
         0: begin len = 20'h1; step = 20'h0; direct = 1'b0; blk = 20'h1; end
         1: begin len = 20'h10000; step = 20'hFFFFF; direct = 1'b0; blk = 20'h10000; end
         2: begin len = 20'h0; step = 20'h10000; direct = 1'b1; blk = 20'h0; end
         3: begin len = 20'hFFFFF; step = 20'h1; direct = 1'b1; blk = 20'h2; end
         default: begin
            case ($urandom_range(0, 6))
               0: len = $urandom_range(1, 4);
               1, 2: len = $urandom_range(5, 48);
               3: len = $urandom_range(49, 65536);
               4: len = 20'h10000;
               5: len = 20'($urandom);
               default: len = 20'h0;
            endcase
            case ($urandom_range(0, 5))
               0: step = 20'h0;
               1: step = 20'h10000;
               2: step = 20'hFFFFF;
               3: step = $urandom_range(0, 20'h3FFFF);
               default: step = 20'($urandom);
            endcase
            case ($urandom_range(0, 4))
               0: blk = 20'h0;
               1: blk = $urandom_range(1, 8);
               2: blk = $urandom_range(1, 64);
               3: blk = 20'h10000;
               default: blk = 20'($urandom);
            endcase
            direct = ($urandom_range(0, 3) == 0);
         end
      endcase
      write_reg(CSR_SOURCE_LENGTH, len);
      write_reg(CSR_STEP_RATIO, step);
      write_reg(CSR_DIRECT_MODE, {19'd0, direct});
      write_reg(CSR_BLOCK_LENGTH, blk);
   endtask

   initial begin : result_sink
      int           stall;
      output_word_t want;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            stall = HOLD_CYCLES;
            hold_request = 1'b0;
         end else if (fast_sink) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         if (pending_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected word, sample_out %h", rsp_sample_out));
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_sample_out !== want.sample)
               report_mismatch($sformatf("sample_out %h, want %h", rsp_sample_out, want.sample));
            if (rsp_last_in_block !== want.last)
               report_mismatch($sformatf("last_in_block %b, want %b", rsp_last_in_block,
                                         want.last));
         end
         if ($urandom_range(0, 63) == 0) fast_sink = !fast_sink;
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      int           phase;
      int           target;
      script_row_t  row;
      output_word_t typed_out;
      regs = '{LEN_RESET, STEP_RESET, DIRECT_RESET, BLOCK_RESET};
      read_pos = 0;
      read_frac = '0;
      block_pos = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         row = SCRIPT[i];
         if (row.kind == ROW_REG) begin
            wait_idle();
            write_reg(row.reg_sel, row.arg);
         end else begin
            typed_out.sample = row.want;
            typed_out.last = row.want_last;
            send_word(row.op, row.arg[15:0], row.val, row.pint, row.pfrac, row.typed,
                      typed_out);
         end
      end

      words_sent = 0;
      phase = 0;
      while (words_sent < RANDOM_WORDS) begin
         wait_idle();
         configure_phase(phase);
         fast_sender = (phase % 3 == 2);
         // stall the output side for a long stretch while words keep coming
         if (phase == 4) begin
            hold_request = 1'b1;
            fast_sender = 1'b1;
         end
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) random_word();
         phase++;
      end

      wait_idle();
      if (mismatch_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
